// ===== hdl/qid_pkg.sv =====
// ----------------------------------------------------------------------------
// qid_pkg: shared types and constants for the queue ID pool allocator
// Sizes of the ID space and handle storage, beat payloads, status codes and
// the write-back bundle between the core and its memories.
// ----------------------------------------------------------------------------
package qid_pkg;

  // Size of the ID space (ID 0 is reserved) and stored handle bits.
  localparam int IdCount    = 4096;
  localparam int HandleBits = 32;

  // Fixed field widths of the beat payloads.
  localparam int QidFieldW    = 12;
  localparam int HandleFieldW = 32;

  // Internal widths derived from the constants above.
  localparam int IdW = $clog2(IdCount);
  localparam int HbW = (HandleBits < HandleFieldW) ? HandleBits : HandleFieldW;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_LOOKUP  = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_EMPTY       = 3'd1,
    ST_BAD_ID      = 3'd2,
    ST_NOT_BOUND   = 3'd3,
    ST_ZERO_HANDLE = 3'd4
  } status_e;

  typedef struct packed {
    logic [1:0]              operation;
    logic [QidFieldW-1:0]    queue_id;
    logic [HandleFieldW-1:0] handle;
  } req_t;

  typedef struct packed {
    status_e                 status;
    logic [QidFieldW-1:0]    granted_id;
    logic [HandleFieldW-1:0] found_handle;
  } resp_t;

  // One write-back to both tables, at the same entry.
  typedef struct packed {
    logic           we;
    logic [IdW-1:0] addr;
    logic [IdW-1:0] link;
    logic [HbW-1:0] handle;
  } wr_t;

endpackage

// ===== hdl/qid_ram.sv =====
// ----------------------------------------------------------------------------
// qid_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle, read data registered.
// ----------------------------------------------------------------------------
module qid_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/qid_core.sv =====
// ----------------------------------------------------------------------------
// qid_core: free-stack and binding read-modify-write engine
// Issues the table read when a beat is taken, then decides the result and
// the write-back in the next cycle from the read data.
// ----------------------------------------------------------------------------
module qid_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  qid_pkg::req_t                req_i,
  input  logic                         exec_i,
  input  logic [qid_pkg::IdW-1:0]      link_rdata_i,
  input  logic [qid_pkg::HbW-1:0]      handle_rdata_i,
  output logic [qid_pkg::IdW-1:0]      rd_addr_o,
  output qid_pkg::wr_t                 wr_o,
  output qid_pkg::resp_t               resp_o
);

  localparam int IdW = qid_pkg::IdW;
  localparam int HbW = qid_pkg::HbW;

  // Free stack top (0 = empty) and lowest ID never handed out.
  logic [IdW-1:0] top_q, top_d;
  logic [IdW:0]   fresh_q, fresh_d;

  // Request captured at the read.
  logic [1:0]     op_q;
  logic           id_ok_q;
  logic [IdW-1:0] addr_q;
  logic [HbW-1:0] handle_q;

  logic           fresh_hit;
  logic [IdW-1:0] fresh_link;
  logic [IdW-1:0] pop_link;
  logic [HbW-1:0] bound;
  logic           id_ok;

  assign rd_addr_o = (req_i.operation == qid_pkg::OP_ALLOC) ? top_q
                                                            : IdW'(req_i.queue_id);
  assign id_ok = (req_i.queue_id != '0) &&
                 (32'(req_i.queue_id) < 32'(qid_pkg::IdCount));

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      op_q     <= req_i.operation;
      id_ok_q  <= id_ok;
      addr_q   <= rd_addr_o;
      handle_q <= HbW'(req_i.handle);
    end
  end

  // Entries at or above the fresh mark were never written: links follow the
  // reset chain and bindings read as zero.
  assign fresh_hit  = ({1'b0, top_q} == fresh_q);
  assign fresh_link = (({1'b0, top_q} + (IdW+1)'(1)) == (IdW+1)'(qid_pkg::IdCount))
                      ? '0 : top_q + IdW'(1);
  assign pop_link   = fresh_hit ? fresh_link : link_rdata_i;
  assign bound      = ({1'b0, addr_q} < fresh_q) ? handle_rdata_i : '0;

  always_comb begin
    top_d         = top_q;
    fresh_d       = fresh_q;
    wr_o.we       = 1'b0;
    wr_o.addr     = addr_q;
    wr_o.link     = top_q;
    wr_o.handle   = '0;
    resp_o        = '0;
    resp_o.status = qid_pkg::ST_OK;
    case (op_q)
      qid_pkg::OP_ALLOC: begin
        if (handle_q == '0) begin
          resp_o.status = qid_pkg::ST_ZERO_HANDLE;
        end else if (top_q == '0) begin
          resp_o.status = qid_pkg::ST_EMPTY;
        end else begin
          resp_o.granted_id = qid_pkg::QidFieldW'(top_q);
          top_d             = pop_link;
          if (fresh_hit) begin
            fresh_d = fresh_q + (IdW+1)'(1);
          end
          wr_o.we     = exec_i;
          wr_o.link   = link_rdata_i;
          wr_o.handle = handle_q;
        end
      end
      qid_pkg::OP_RELEASE: begin
        if (!id_ok_q) begin
          resp_o.status = qid_pkg::ST_BAD_ID;
        end else if (bound == '0) begin
          resp_o.status = qid_pkg::ST_NOT_BOUND;
        end else begin
          wr_o.we   = exec_i;
          wr_o.link = top_q;
          top_d     = addr_q;
        end
      end
      qid_pkg::OP_LOOKUP: begin
        if (!id_ok_q) begin
          resp_o.status = qid_pkg::ST_BAD_ID;
        end else begin
          resp_o.found_handle = qid_pkg::HandleFieldW'(bound);
        end
      end
      default: begin
        resp_o.status = qid_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q   <= IdW'(1);
      fresh_q <= (IdW+1)'(1);
    end else if (exec_i) begin
      top_q   <= top_d;
      fresh_q <= fresh_d;
    end
  end

endmodule

// ===== hdl/queue_id_pool_allocator.sv =====
// ----------------------------------------------------------------------------
// queue_id_pool_allocator: LIFO free-list ID allocator with handle bindings
// Allocate pops an ID and binds a handle, release unbinds and pushes it back,
// lookup returns the bound handle. Link and handle tables sit in RAM.
// ----------------------------------------------------------------------------
//
//  channel | valid      | ready      | payload     | beat
//  --------+------------+------------+-------------+---------------------------
//  request | in_valid_i | in_ready_o | in_data_i   | op, queue_id, handle
//  result  | out_valid_o| out_ready_i| out_data_o  | status, granted_id, handle
//
// Requests are handled one at a time: the table read issued at acceptance
// returns in the next cycle, when the core decides and writes back. That
// read-then-write of the synchronous RAMs limits the request rate.
// After reset the block is ready at once: no clearing pass; a fresh-ID mark
// stands in for the reset contents of both tables.
// A held result beat stalls intake until it is taken; the next request is
// accepted in the same cycle the result drains.

module queue_id_pool_allocator (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  qid_pkg::req_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output qid_pkg::resp_t out_data_o
);

  localparam int IdW = qid_pkg::IdW;
  localparam int HbW = qid_pkg::HbW;

  logic           busy_q;
  logic           out_valid_q;
  qid_pkg::resp_t out_q;
  logic           accept;

  logic [IdW-1:0] rd_addr;
  logic [IdW-1:0] link_rdata;
  logic [HbW-1:0] handle_rdata;
  qid_pkg::wr_t   wr;
  qid_pkg::resp_t resp;

  // Take a beat only when idle and the result slot is free or draining.
  assign in_ready_o = !busy_q && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q <= accept;
      if (busy_q) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold the result until taken; load only when the core finishes.
  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      out_q <= resp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  qid_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (accept),
    .req_i          (in_data_i),
    .exec_i         (busy_q),
    .link_rdata_i   (link_rdata),
    .handle_rdata_i (handle_rdata),
    .rd_addr_o      (rd_addr),
    .wr_o           (wr),
    .resp_o         (resp)
  );

  // Next-free link per ID.
  qid_ram #(
    .Width (IdW),
    .Depth (qid_pkg::IdCount)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (wr.we),
    .waddr_i (wr.addr),
    .wdata_i (wr.link),
    .re_i    (accept),
    .raddr_i (rd_addr),
    .rdata_o (link_rdata)
  );

  // Bound handle per ID, zero when unbound.
  qid_ram #(
    .Width (HbW),
    .Depth (qid_pkg::IdCount)
  ) u_handle_ram (
    .clk_i   (clk_i),
    .we_i    (wr.we),
    .waddr_i (wr.addr),
    .wdata_i (wr.handle),
    .re_i    (accept),
    .raddr_i (rd_addr),
    .rdata_o (handle_rdata)
  );

  // An accepted beat yields a result beat once busy_q has passed it to out_valid_q.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> ##1 out_valid_o)
    else $error("result beat missing after accepted request");

  // Table write-back happens only in the execute cycle.
  a_write_in_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr.we |-> busy_q && !in_ready_o)
    else $error("table write outside execute cycle");

  // A granted ID always comes with status ok.
  a_grant_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.granted_id != '0) |-> out_data_o.status == qid_pkg::ST_OK)
    else $error("granted ID with failing status");

  // A found handle always comes with status ok and no grant.
  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.found_handle != '0) |->
      (out_data_o.status == qid_pkg::ST_OK) && (out_data_o.granted_id == '0))
    else $error("found handle with failing status or grant");

endmodule
